### rtl/rmm_pkg.sv
// shared types and constants of the rendezvous message matcher
`timescale 1ns / 1ps

package rmm_pkg;

  localparam int NodeW = 3;
  localparam int ProcW = 4;
  localparam int TickW = 32;

  typedef enum logic {
    FUNC_SEND = 1'b0,
    FUNC_RECV = 1'b1
  } rmm_func_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_WAIT = 2'd1,
    ST_DONE = 2'd2
  } rmm_status_e;

  typedef struct packed {
    rmm_func_e              func;
    logic [NodeW-1:0]       src_node;
    logic [ProcW-1:0]       sender_process;
    logic [NodeW-1:0]       dst_node;
    logic [ProcW-1:0]       receiver_process;
    logic [TickW-1:0]       tick;
  } rmm_req_t;

  typedef struct packed {
    logic                   matched;
    logic [1:0]             sender_status;
    logic [1:0]             receiver_status;
    logic [TickW-1:0]       done_tick;
  } rmm_rsp_t;

  typedef struct packed {
    rmm_status_e            status;
    logic [NodeW-1:0]       pnode;
    logic [ProcW-1:0]       pproc;
  } rmm_slot_t;

  typedef struct packed {
    logic                   send_we;
    rmm_slot_t              send_slot;
    logic                   recv_we;
    rmm_slot_t              recv_slot;
  } rmm_upd_t;

  localparam rmm_slot_t SlotIdle = '{status: ST_IDLE, pnode: '0, pproc: '0};

endpackage

### rtl/rmm_slot_table.sv
// slot table: memory with per-entry valid bits and write-to-read bypass
`timescale 1ns / 1ps

module rmm_slot_table
  import rmm_pkg::*;
#(
  parameter int DEPTH = 128,
  parameter int IDX_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  rmm_slot_t        wr_data_i,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output rmm_slot_t        rd_data_o
);

  rmm_slot_t        mem [DEPTH];
  rmm_slot_t        rd_q;
  logic [DEPTH-1:0] valid_q;
  logic             rd_valid_q;
  logic             bypass;

  assign bypass = wr_en_i && (wr_addr_i == rd_addr_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= bypass ? wr_data_i : mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= bypass | valid_q[rd_addr_i];
      end
    end
  end

  // entries never written read as idle
  assign rd_data_o = rd_valid_q ? rd_q : SlotIdle;

endmodule

### rtl/rmm_match.sv
// match logic: new slot contents and result for one request
`timescale 1ns / 1ps

module rmm_match
  import rmm_pkg::*;
(
  input  rmm_req_t  req_i,
  input  logic      in_range_i,
  input  rmm_slot_t send_slot_i,
  input  rmm_slot_t recv_slot_i,
  output rmm_upd_t  upd_o,
  output rmm_rsp_t  rsp_o
);

  logic      match;
  rmm_slot_t send_new;
  rmm_slot_t recv_new;

  always_comb begin
    send_new = send_slot_i;
    recv_new = recv_slot_i;
    match    = 1'b0;
    unique case (req_i.func)
      FUNC_SEND: begin
        send_new = '{status: ST_WAIT, pnode: req_i.dst_node,
                     pproc: req_i.receiver_process};
        match    = (recv_slot_i.status == ST_WAIT) &&
                   (recv_slot_i.pnode == req_i.src_node) &&
                   (recv_slot_i.pproc == req_i.sender_process);
      end
      FUNC_RECV: begin
        recv_new = '{status: ST_WAIT, pnode: req_i.src_node,
                     pproc: req_i.sender_process};
        match    = (send_slot_i.status == ST_WAIT) &&
                   (send_slot_i.pnode == req_i.dst_node) &&
                   (send_slot_i.pproc == req_i.receiver_process);
      end
      default: begin
        match = 1'b0;
      end
    endcase
    if (match) begin
      send_new.status = ST_DONE;
      recv_new.status = ST_DONE;
    end
  end

  always_comb begin
    upd_o.send_slot = send_new;
    upd_o.recv_slot = recv_new;
    upd_o.send_we   = in_range_i && (match || (req_i.func == FUNC_SEND));
    upd_o.recv_we   = in_range_i && (match || (req_i.func == FUNC_RECV));
    if (in_range_i) begin
      rsp_o.matched         = match;
      rsp_o.sender_status   = send_new.status;
      rsp_o.receiver_status = recv_new.status;
      rsp_o.done_tick       = match ? req_i.tick : '0;
    end else begin
      rsp_o = '0;
    end
  end

endmodule

### rtl/rendezvous_message_matcher.sv
// top level of the rendezvous message matcher
`timescale 1ns / 1ps

// Send/receive rendezvous table with one send slot and one receive slot per
// (node, process). One request is accepted every cycle unless the output is
// stalled; its result is matched from the registered request and slot reads,
// then held in the output register. The rate is set by the two slot tables:
// each is read once when a request is taken and written once when it
// completes, with a bypass so that back-to-back requests on the same slot see
// the latest contents. Slots reset to idle at once through per-entry valid
// bits, so no clearing pass follows reset. Node indexes at or above NODES and
// process indexes at or above PROCS are ignored and give an all-zero result.

module rendezvous_message_matcher
  import rmm_pkg::*;
#(
  parameter int NODES = 8,
  parameter int PROCS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  rmm_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output rmm_rsp_t out_rsp_o
);

  localparam int NodesEff = (NODES < (1 << NodeW)) ? NODES : (1 << NodeW);
  localparam int ProcsEff = (PROCS < (1 << ProcW)) ? PROCS : (1 << ProcW);
  localparam int Depth    = NodesEff * ProcsEff;
  localparam int IdxW     = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int RawW     = NodeW + ProcW + 1;

  rmm_req_t        req_q;
  logic            a_valid_q;
  rmm_rsp_t        rsp_q;
  logic            out_valid_q;
  logic            accept;
  logic            advance;
  logic            in_range_in;
  logic            in_range_q;
  logic [RawW-1:0] send_raw;
  logic [RawW-1:0] recv_raw;
  logic [IdxW-1:0] send_rd_addr;
  logic [IdxW-1:0] recv_rd_addr;
  logic [IdxW-1:0] send_addr_q;
  logic [IdxW-1:0] recv_addr_q;
  rmm_slot_t       send_slot;
  rmm_slot_t       recv_slot;
  rmm_upd_t        upd;
  rmm_rsp_t        rsp;
  logic            write_go;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !a_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;
  assign write_go   = a_valid_q && advance;

  assign in_range_in = (32'(in_req_i.src_node) < NODES) &&
                       (32'(in_req_i.dst_node) < NODES) &&
                       (32'(in_req_i.sender_process) < PROCS) &&
                       (32'(in_req_i.receiver_process) < PROCS);

  assign send_raw = RawW'(RawW'(in_req_i.src_node) * RawW'(ProcsEff)) +
                    RawW'(in_req_i.sender_process);
  assign recv_raw = RawW'(RawW'(in_req_i.dst_node) * RawW'(ProcsEff)) +
                    RawW'(in_req_i.receiver_process);

  assign send_rd_addr = in_range_in ? send_raw[IdxW-1:0] : '0;
  assign recv_rd_addr = in_range_in ? recv_raw[IdxW-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q       <= in_req_i;
      in_range_q  <= in_range_in;
      send_addr_q <= send_rd_addr;
      recv_addr_q <= recv_rd_addr;
    end
    if (write_go) begin
      rsp_q <= rsp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        a_valid_q <= 1'b1;
      end else if (advance) begin
        a_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= a_valid_q;
      end
    end
  end

  rmm_slot_table #(
    .DEPTH (Depth),
    .IDX_W (IdxW)
  ) u_send_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (write_go && upd.send_we),
    .wr_addr_i (send_addr_q),
    .wr_data_i (upd.send_slot),
    .rd_en_i   (accept),
    .rd_addr_i (send_rd_addr),
    .rd_data_o (send_slot)
  );

  rmm_slot_table #(
    .DEPTH (Depth),
    .IDX_W (IdxW)
  ) u_recv_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (write_go && upd.recv_we),
    .wr_addr_i (recv_addr_q),
    .wr_data_i (upd.recv_slot),
    .rd_en_i   (accept),
    .rd_addr_i (recv_rd_addr),
    .rd_data_o (recv_slot)
  );

  rmm_match u_match (
    .req_i       (req_q),
    .in_range_i  (in_range_q),
    .send_slot_i (send_slot),
    .recv_slot_i (recv_slot),
    .upd_o       (upd),
    .rsp_o       (rsp)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule
